// ===== hw/rtl/tss_pkg.sv =====
`timescale 1ns / 1ps
package tss_pkg;

  // default configuration
  localparam int DEF_SURVIVORS     = 32;
  localparam int DEF_POOL_DEPTH    = 128;
  localparam int DEF_FITNESS_WIDTH = 32;

  // placement count is limited by the slot field
  localparam int MAX_OUT = 32;

  // field widths
  localparam int ITEM_FIT_W = 32;
  localparam int SRC_W      = 2;
  localparam int IDX_W      = 7;
  localparam int SLOT_W     = 5;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  // source codes
  localparam logic [SRC_W-1:0] SRC_POP     = 2'd0;
  localparam logic [SRC_W-1:0] SRC_OFFS    = 2'd1;
  localparam logic [SRC_W-1:0] SRC_MUTANT  = 2'd2;
  localparam logic [SRC_W-1:0] SRC_INVALID = 2'd3;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORTP,
    ST_EMITP,
    ST_EMITN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // candidate transfer this cycle
    logic sortp;    // insert ranked entry k into population list if it is one
    logic rewind;   // walk pointer back to zero
    logic emitp;    // emit population entry k
    logic emitn;    // emit ranked entry k if not a population member
    logic finish;   // run complete, empty the pool
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_end;  // walk pointer reached ranked count
    logic pop_end;   // walk pointer reached population count
    logic out_free;  // output register can take a placement
  } status_t;

endpackage

// ===== hw/rtl/tss_ctrl.sv =====
`timescale 1ns / 1ps
module tss_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tlast,
  output logic             in_tready,
  input  tss_pkg::status_t st,
  output tss_pkg::cmd_t    cmd
);
  import tss_pkg::*;

  state_t state_r, state_nxt;
  logic   acc;

  assign acc = in_tvalid && in_tready;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (acc && in_tlast) state_nxt = ST_SORTP;
      end
      ST_SORTP: begin
        if (st.walk_end) state_nxt = ST_EMITP;
      end
      ST_EMITP: begin
        if (st.pop_end) state_nxt = ST_EMITN;
      end
      ST_EMITN: begin
        if (st.walk_end) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        cmd.load  = acc;
      end
      ST_SORTP: begin
        cmd.sortp  = !st.walk_end;
        cmd.rewind = st.walk_end;
      end
      ST_EMITP: begin
        cmd.rewind = st.pop_end;
        cmd.emitp  = !st.pop_end && st.out_free;
      end
      ST_EMITN: begin
        cmd.finish = st.walk_end;
        cmd.emitn  = !st.walk_end && st.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hw/rtl/tss_datapath.sv =====
`timescale 1ns / 1ps
module tss_datapath #(
  parameter int SURVIVORS     = tss_pkg::DEF_SURVIVORS,
  parameter int POOL_DEPTH    = tss_pkg::DEF_POOL_DEPTH,
  parameter int FITNESS_WIDTH = tss_pkg::DEF_FITNESS_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tss_pkg::cmd_t                  cmd,
  output tss_pkg::status_t               st,
  input  logic [tss_pkg::ITEM_FIT_W-1:0] item_fitness,
  input  logic [tss_pkg::SRC_W-1:0]      item_source,
  input  logic [tss_pkg::IDX_W-1:0]      item_index,
  input  logic                           item_last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tss_pkg::SLOT_W-1:0]     dest_slot,
  output logic [tss_pkg::SRC_W-1:0]      pick_source,
  output logic [tss_pkg::IDX_W-1:0]      pick_index,
  output logic                           pick_last
);
  import tss_pkg::*;

  localparam int K   = (SURVIVORS < MAX_OUT) ? SURVIVORS : MAX_OUT;
  localparam int KW  = (K > 1) ? $clog2(K) : 1;
  localparam int CW  = $clog2(K + 1);
  localparam int PCW = $clog2(POOL_DEPTH + 1);
  localparam int FB  = (FITNESS_WIDTH < 32) ? FITNESS_WIDTH : 32;

  // ranked list, best first
  logic signed [FB-1:0] fit_r [K];
  logic [SRC_W-1:0]     src_r [K];
  logic [IDX_W-1:0]     idx_r [K];
  logic signed [FB-1:0] fit_nxt [K];
  logic [SRC_W-1:0]     src_nxt [K];
  logic [IDX_W-1:0]     idx_nxt [K];
  logic [CW-1:0]        topn_r, topn_nxt;

  // population survivors by ascending index
  logic [IDX_W-1:0]     pidx_r [K];
  logic [IDX_W-1:0]     pidx_nxt [K];
  logic [CW-1:0]        np_r, np_nxt;

  logic [PCW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]        k_r, k_nxt;
  logic [CW-1:0]        e_r, e_nxt;

  logic                 ov_r, ov_nxt;
  logic [SLOT_W-1:0]    oslot_r, oslot_nxt;
  logic [SRC_W-1:0]     osrc_r, osrc_nxt;
  logic [IDX_W-1:0]     oidx_r, oidx_nxt;
  logic                 olast_r, olast_nxt;

  logic signed [FB-1:0] new_fit;
  logic                 store;
  logic [K-1:0]         ahead, pahead;
  logic [KW-1:0]        ka;
  logic [SRC_W-1:0]     k_src;
  logic [IDX_W-1:0]     k_idx;
  logic [IDX_W-1:0]     k_pidx;
  logic                 emit;

  assign new_fit = item_fitness[FB-1:0];
  assign store   = cmd.load && (item_source != SRC_INVALID)
                   && (cnt_r < PCW'(POOL_DEPTH));
  assign ka      = k_r[KW-1:0];
  assign k_src   = src_r[ka];
  assign k_idx   = idx_r[ka];
  assign k_pidx  = pidx_r[ka];

  assign st.walk_end = (k_r == topn_r);
  assign st.pop_end  = (k_r == np_r);
  assign st.out_free = !ov_r || out_ready;

  // entries that stay ahead of the newcomer; ties keep arrival order
  always_comb begin
    for (int j = 0; j < K; j++) begin
      ahead[j]  = (CW'(j) < topn_r) && (fit_r[j] >= new_fit);
      pahead[j] = (CW'(j) < np_r) && (pidx_r[j] <= k_idx);
    end
  end

  // ranked list insertion
  always_comb begin
    for (int j = 0; j < K; j++) begin
      fit_nxt[j] = fit_r[j];
      src_nxt[j] = src_r[j];
      idx_nxt[j] = idx_r[j];
      if (store && !ahead[j]) begin
        if (j == 0 || ahead[(j > 0) ? j - 1 : 0]) begin
          fit_nxt[j] = new_fit;
          src_nxt[j] = item_source;
          idx_nxt[j] = item_index;
        end else begin
          fit_nxt[j] = fit_r[(j > 0) ? j - 1 : 0];
          src_nxt[j] = src_r[(j > 0) ? j - 1 : 0];
          idx_nxt[j] = idx_r[(j > 0) ? j - 1 : 0];
        end
      end
    end
  end

  // population list insertion by index
  always_comb begin
    for (int j = 0; j < K; j++) begin
      pidx_nxt[j] = pidx_r[j];
      if (cmd.sortp && (k_src == SRC_POP) && !pahead[j]) begin
        if (j == 0 || pahead[(j > 0) ? j - 1 : 0]) begin
          pidx_nxt[j] = k_idx;
        end else begin
          pidx_nxt[j] = pidx_r[(j > 0) ? j - 1 : 0];
        end
      end
    end
  end

  // counters and walk pointer
  always_comb begin
    topn_nxt = topn_r;
    np_nxt   = np_r;
    cnt_nxt  = cnt_r;
    k_nxt    = k_r;
    e_nxt    = e_r;
    if (store) begin
      cnt_nxt = cnt_r + PCW'(1);
      if (topn_r != CW'(K)) topn_nxt = topn_r + CW'(1);
    end
    if (cmd.load && item_last) k_nxt = '0;
    if (cmd.sortp) begin
      k_nxt = k_r + CW'(1);
      if (k_src == SRC_POP) np_nxt = np_r + CW'(1);
    end
    if (cmd.rewind) k_nxt = '0;
    if (cmd.emitp || cmd.emitn) k_nxt = k_r + CW'(1);
    if (emit) e_nxt = e_r + CW'(1);
    if (cmd.finish) begin
      topn_nxt = '0;
      np_nxt   = '0;
      cnt_nxt  = '0;
      k_nxt    = '0;
      e_nxt    = '0;
    end
  end

  // output register
  assign emit = cmd.emitp || (cmd.emitn && (k_src != SRC_POP));

  always_comb begin
    ov_nxt    = ov_r && !out_ready;
    oslot_nxt = oslot_r;
    osrc_nxt  = osrc_r;
    oidx_nxt  = oidx_r;
    olast_nxt = olast_r;
    if (emit) begin
      ov_nxt    = 1'b1;
      oslot_nxt = SLOT_W'(e_r);
      osrc_nxt  = cmd.emitp ? SRC_POP : k_src;
      oidx_nxt  = cmd.emitp ? k_pidx : k_idx;
      olast_nxt = (e_r == topn_r - CW'(1));
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      topn_r <= '0;
      np_r   <= '0;
      cnt_r  <= '0;
      k_r    <= '0;
      e_r    <= '0;
      ov_r   <= 1'b0;
    end else begin
      topn_r <= topn_nxt;
      np_r   <= np_nxt;
      cnt_r  <= cnt_nxt;
      k_r    <= k_nxt;
      e_r    <= e_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    for (int j = 0; j < K; j++) begin
      fit_r[j]  <= fit_nxt[j];
      src_r[j]  <= src_nxt[j];
      idx_r[j]  <= idx_nxt[j];
      pidx_r[j] <= pidx_nxt[j];
    end
    oslot_r <= oslot_nxt;
    osrc_r  <= osrc_nxt;
    oidx_r  <= oidx_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid   = ov_r;
  assign dest_slot   = oslot_r;
  assign pick_source = osrc_r;
  assign pick_index  = oidx_r;
  assign pick_last   = olast_r;

endmodule

// ===== hw/rtl/truncation_survivor_selector_unit.sv =====
`timescale 1ns / 1ps
// Truncation survivor selection over a candidate pool.
// Input stream: one candidate per transfer, fitness and index in in_tdata,
// source in in_tuser, in_tlast on the final candidate of the pool.
// in_tready stays high while loading; each candidate is inserted into a
// ranked list of the best min(SURVIVORS, 32) entries by a parallel compare
// and shift, ties ranked by arrival. Candidates with source 3 or beyond
// POOL_DEPTH are dropped.
// After in_tlast, in_tready falls while the run is finished: the walk pointer
// first steps over the ranked list to sort surviving population members by
// index, then emits each population placement, then walks the ranked list
// again to emit the entries that are not population members.
// Output stream: one placement per transfer, slot and index in out_tdata,
// source in out_tuser, out_tlast on the final placement. Placements go out
// through one output register; a stalled receiver holds the walk.
// Reset empties the pool and drops any placement in flight.
module truncation_survivor_selector_unit #(
  parameter int SURVIVORS     = tss_pkg::DEF_SURVIVORS,
  parameter int POOL_DEPTH    = tss_pkg::DEF_POOL_DEPTH,
  parameter int FITNESS_WIDTH = tss_pkg::DEF_FITNESS_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [tss_pkg::IN_DATA_W-1:0]  in_tdata,  // item_fitness[31:0], item_index[38:32]
  input  logic [tss_pkg::SRC_W-1:0]      in_tuser,  // item_source[1:0]
  input  logic                           in_tlast,  // item_last
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [tss_pkg::OUT_DATA_W-1:0] out_tdata, // dest_slot[4:0], pick_index[11:5]
  output logic [tss_pkg::SRC_W-1:0]      out_tuser, // pick_source[1:0]
  output logic                           out_tlast  // pick_last
);
  import tss_pkg::*;

  cmd_t              cmd;
  status_t           st;
  logic [SLOT_W-1:0] dest_slot;
  logic [IDX_W-1:0]  pick_index;

  tss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  tss_datapath #(
    .SURVIVORS     (SURVIVORS),
    .POOL_DEPTH    (POOL_DEPTH),
    .FITNESS_WIDTH (FITNESS_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .st           (st),
    .item_fitness (in_tdata[ITEM_FIT_W-1:0]),
    .item_source  (in_tuser),
    .item_index   (in_tdata[ITEM_FIT_W+IDX_W-1:ITEM_FIT_W]),
    .item_last    (in_tlast),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .dest_slot    (dest_slot),
    .pick_source  (out_tuser),
    .pick_index   (pick_index),
    .pick_last    (out_tlast)
  );

  assign out_tdata = {{(OUT_DATA_W - SLOT_W - IDX_W){1'b0}}, pick_index, dest_slot};

endmodule
